// File: hdl/rau_pkg.sv
package rau_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int NUM_W = 32;
  localparam int DEN_W = 31;

  localparam logic [1:0] FN_ADD = 2'd0;
  localparam logic [1:0] FN_SUB = 2'd1;
  localparam logic [1:0] FN_MUL = 2'd2;
  localparam logic [1:0] FN_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MINIT,
    S_MUL,
    S_COMB,
    S_COMB2,
    S_GCD,
    S_GSH,
    S_DINIT,
    S_DIV,
    S_FINAL
  } state_t;

endpackage

// File: hdl/rational_arith_unit.sv
// Sequence from the accepting edge to done: division by zero ends at the check;
// a zero denominator ends once the products are formed; else a binary GCD runs,
// taking out and later restoring common factors of two, and two divides follow;
// add and subtract form one more product, plus a step if the difference is negative.
// A new word is taken only while idle; busy falls as done rises.
// Reset: synchronous rst idles the sequencer with done low; the receiver cannot stall.
module rational_arith_unit #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        func,
  input  logic signed [31:0]                a_num,
  input  logic signed [31:0]                a_den,
  input  logic signed [31:0]                b_num,
  input  logic signed [31:0]                b_den,
  output logic                              done,
  output logic signed [rau_pkg::NUM_W-1:0]  res_num,
  output logic [rau_pkg::DEN_W-1:0]         res_den,
  output logic [1:0]                        status
);

  localparam int PW = 2 * WIDTH;
  localparam int CW = $clog2(PW + 1);
  localparam logic [PW-1:0] LIM = PW'(1) << (WIDTH - 1);

  rau_pkg::state_t state, state_next;

  logic [1:0]       fn;
  logic             an_s, ad_s, bn_s, bd_s;
  logic [WIDTH-1:0] an, ad, bn, bd;
  logic             s0, s1, s2;
  logic [1:0]       jsel;
  logic [PW-1:0]    acc, ma, p0, p1, p2;
  logic [WIDTH-1:0] mb;
  logic [CW-1:0]    cnt, k;
  logic [PW-1:0]    nmag, x, y, q, nq, dq;
  logic             nneg, dsel;
  logic [PW:0]      rem, rem_sh;

  logic [PW:0]      add_a, add_b, add_sum;
  logic             add_sub, add_borrow;

  logic             fin;
  logic [1:0]       fin_status;
  logic             neg, ovf, mul_last, div_last, addsub;
  logic [WIDTH-1:0] numw;
  logic [PW-1:0]    q_new;

  function automatic logic [WIDTH-1:0] mag_of(input logic [31:0] raw);
    logic [WIDTH-1:0] v;
    v = raw[WIDTH-1:0];
    return v[WIDTH-1] ? (WIDTH'(0) - v) : v;
  endfunction

  rau_addsub #(.W(PW + 1)) u_addsub (
    .a(add_a), .b(add_b), .sub(add_sub), .sum(add_sum), .borrow(add_borrow)
  );

  assign busy = (state != rau_pkg::S_IDLE);
  assign mul_last = (cnt == CW'(WIDTH - 1));
  assign div_last = (cnt == CW'(PW - 1));
  assign addsub = (fn == rau_pkg::FN_ADD) || (fn == rau_pkg::FN_SUB);
  assign rem_sh = {rem[PW-1:0], q[PW-1]};
  assign q_new = {q[PW-2:0], ~add_borrow};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::S_IDLE: begin
        if (start) state_next = rau_pkg::S_CHECK;
      end
      rau_pkg::S_CHECK: begin
        if (fn == rau_pkg::FN_DIV && bn == '0) state_next = rau_pkg::S_IDLE;
        else state_next = rau_pkg::S_MINIT;
      end
      rau_pkg::S_MINIT: state_next = rau_pkg::S_MUL;
      rau_pkg::S_MUL: begin
        if (mul_last) begin
          state_next = (jsel == 2'd2) ? rau_pkg::S_COMB : rau_pkg::S_MINIT;
        end
      end
      rau_pkg::S_COMB: begin
        if (p2 == '0) state_next = rau_pkg::S_IDLE;
        else if (addsub && s0 != s1 && add_borrow) state_next = rau_pkg::S_COMB2;
        else state_next = rau_pkg::S_GCD;
      end
      rau_pkg::S_COMB2: state_next = rau_pkg::S_GCD;
      rau_pkg::S_GCD: begin
        if (x == '0) state_next = rau_pkg::S_GSH;
      end
      rau_pkg::S_GSH: begin
        if (k == '0) state_next = rau_pkg::S_DINIT;
      end
      rau_pkg::S_DINIT: state_next = rau_pkg::S_DIV;
      rau_pkg::S_DIV: begin
        if (div_last) state_next = dsel ? rau_pkg::S_FINAL : rau_pkg::S_DINIT;
      end
      rau_pkg::S_FINAL: state_next = rau_pkg::S_IDLE;
      default: state_next = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    add_a = '0;
    add_b = '0;
    add_sub = 1'b0;
    fin = 1'b0;
    fin_status = rau_pkg::ST_OK;
    neg = (nneg != s2) && (nq != '0);
    ovf = (dq > LIM - PW'(1)) || (neg ? (nq > LIM) : (nq > LIM - PW'(1)));
    numw = neg ? (WIDTH'(0) - nq[WIDTH-1:0]) : nq[WIDTH-1:0];
    unique case (state)
      rau_pkg::S_MUL: begin
        add_a = {1'b0, acc};
        add_b = mb[0] ? {1'b0, ma} : '0;
      end
      rau_pkg::S_COMB: begin
        add_a = {1'b0, p0};
        add_b = {1'b0, p1};
        add_sub = (s0 != s1);
      end
      rau_pkg::S_COMB2: begin
        add_a = {1'b0, p1};
        add_b = {1'b0, p0};
        add_sub = 1'b1;
      end
      rau_pkg::S_GCD: begin
        add_a = {1'b0, x};
        add_b = {1'b0, y};
        add_sub = 1'b1;
      end
      rau_pkg::S_DIV: begin
        add_a = rem_sh;
        add_b = {1'b0, y};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
    unique case (state)
      rau_pkg::S_CHECK: begin
        if (fn == rau_pkg::FN_DIV && bn == '0) begin
          fin = 1'b1;
          fin_status = rau_pkg::ST_DIVZ;
        end
      end
      rau_pkg::S_COMB: begin
        if (p2 == '0) begin
          fin = 1'b1;
          fin_status = rau_pkg::ST_ZDEN;
        end
      end
      rau_pkg::S_FINAL: begin
        fin = 1'b1;
        fin_status = ovf ? rau_pkg::ST_OVF : rau_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      status <= fin_status;
      if (fin_status == rau_pkg::ST_OK) begin
        res_num <= rau_pkg::NUM_W'($signed(numw));
        res_den <= rau_pkg::DEN_W'(dq[WIDTH-2:0]);
      end else begin
        res_num <= '0;
        res_den <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rau_pkg::S_IDLE: begin
        fn <= func;
        an_s <= a_num[WIDTH-1];
        ad_s <= a_den[WIDTH-1];
        bn_s <= b_num[WIDTH-1];
        bd_s <= b_den[WIDTH-1];
        an <= mag_of(a_num);
        ad <= mag_of(a_den);
        bn <= mag_of(b_num);
        bd <= mag_of(b_den);
        jsel <= 2'd0;
        dsel <= 1'b0;
      end
      rau_pkg::S_CHECK: begin
        s0 <= an_s ^ ((fn == rau_pkg::FN_MUL) ? bn_s : bd_s);
        s1 <= bn_s ^ ad_s ^ (fn == rau_pkg::FN_SUB);
        s2 <= ad_s ^ ((fn == rau_pkg::FN_DIV) ? bn_s : bd_s);
      end
      rau_pkg::S_MINIT: begin
        acc <= '0;
        cnt <= '0;
        case (jsel)
          2'd0: begin
            ma <= PW'(an);
            mb <= (fn == rau_pkg::FN_MUL) ? bn : bd;
          end
          2'd1: begin
            ma <= PW'(bn);
            mb <= ad;
          end
          default: begin
            ma <= PW'(ad);
            mb <= (fn == rau_pkg::FN_DIV) ? bn : bd;
          end
        endcase
      end
      rau_pkg::S_MUL: begin
        acc <= add_sum[PW-1:0];
        ma <= {ma[PW-2:0], 1'b0};
        mb <= {1'b0, mb[WIDTH-1:1]};
        cnt <= cnt + CW'(1);
        if (mul_last) begin
          case (jsel)
            2'd0: p0 <= add_sum[PW-1:0];
            2'd1: p1 <= add_sum[PW-1:0];
            default: p2 <= add_sum[PW-1:0];
          endcase
          jsel <= (jsel == 2'd0 && addsub) ? 2'd1 : 2'd2;
        end
      end
      rau_pkg::S_COMB: begin
        y <= p2;
        k <= '0;
        nneg <= s0;
        if (addsub) begin
          nmag <= add_sum[PW-1:0];
          x <= add_sum[PW-1:0];
        end else begin
          nmag <= p0;
          x <= p0;
        end
      end
      rau_pkg::S_COMB2: begin
        nmag <= add_sum[PW-1:0];
        x <= add_sum[PW-1:0];
        nneg <= s1;
      end
      rau_pkg::S_GCD: begin
        if (x != '0) begin
          if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + CW'(1);
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (!add_borrow) begin
            x <= add_sum[PW-1:0];
          end else begin
            x <= y;
            y <= x;
          end
        end
      end
      rau_pkg::S_GSH: begin
        if (k != '0) begin
          y <= y << 1;
          k <= k - CW'(1);
        end
      end
      rau_pkg::S_DINIT: begin
        rem <= '0;
        q <= dsel ? p2 : nmag;
        cnt <= '0;
      end
      rau_pkg::S_DIV: begin
        q <= q_new;
        rem <= add_borrow ? rem_sh : add_sum;
        cnt <= cnt + CW'(1);
        if (div_last) begin
          if (!dsel) begin
            nq <= q_new;
            dsel <= 1'b1;
          end else begin
            dq <= q_new;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/rau_addsub.sv
module rau_addsub #(
  parameter int W = 65
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         borrow
);

  logic [W:0] s;

  assign s = {1'b0, a} + (sub ? ~{1'b0, b} : {1'b0, b}) + {{W{1'b0}}, sub};
  assign sum = s[W-1:0];
  assign borrow = sub & s[W];

endmodule

// File: hdl/rau_chk.sv
module rau_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic signed [31:0] res_num,
  input logic [30:0]       res_den,
  input logic [1:0]        status
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != rau_pkg::ST_OK) |-> (res_num == '0 && res_den == '0))
    else $error("error result not zero");

  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    (done && status == rau_pkg::ST_OK) |-> (res_den != '0))
    else $error("ok result with zero denominator");

  a_reset: assert property (@(posedge clk)
    rst |=> (!busy && !done)) else $error("not idle after reset");

endmodule

bind rational_arith_unit rau_chk u_rau_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .res_num(res_num), .res_den(res_den), .status(status)
);
